FILE: design/gmc_pkg.sv
// gmc_pkg: shared types and codes for the gate motion controller.
// Holds the poll and report payload structs, phase enum and status codes.
// No dependencies.
package gmc_pkg;

  // Sequencer phases
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_DECIDE  = 3'd1,
    PH_OPENING = 3'd2,
    PH_CLOSING = 3'd3,
    PH_STOP    = 3'd4
  } phase_t;

  // Gate status codes
  localparam logic [2:0] GATE_UNKNOWN    = 3'd0;
  localparam logic [2:0] GATE_OPEN       = 3'd1;
  localparam logic [2:0] GATE_OPENING    = 3'd2;
  localparam logic [2:0] GATE_OPEN_STOP  = 3'd3;
  localparam logic [2:0] GATE_SHUT       = 3'd4;
  localparam logic [2:0] GATE_CLOSING    = 3'd5;
  localparam logic [2:0] GATE_CLOSE_STOP = 3'd6;

  // Status LED codes
  localparam logic [1:0] LED_OK     = 2'd0;
  localparam logic [1:0] LED_MOVING = 2'd1;
  localparam logic [1:0] LED_ERROR  = 2'd2;

  // Timeout limit after reset
  localparam logic [7:0] TIMEOUT_LIMIT_RESET = 8'd3;

  // One poll of the controller inputs
  typedef struct packed {
    logic push_button;
    logic open_limit;
    logic closed_limit;
    logic photocell;
    logic remote_start;
    logic timeout_tick;
    logic hold_tick;
  } poll_t;

  // One report of the controller outputs
  typedef struct packed {
    logic       open_out;
    logic       close_out;
    logic [2:0] gate_status;
    logic       error_flag;
    logic [1:0] status_led;
    logic [2:0] controller_phase;
    logic [3:0] status_byte;
  } report_t;

endpackage

FILE: design/gmc_if.sv
// gmc_if: valid/ready channel interfaces for polls, reports and configuration.
// Depends on gmc_pkg for the payload types.

interface gmc_poll_if;
  logic           valid;
  logic           ready;
  gmc_pkg::poll_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gmc_report_if;
  logic             valid;
  logic             ready;
  gmc_pkg::report_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gmc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: design/gate_motion_controller.sv
// Gate motion controller: an accepted poll's report is registered into the output register,
// or into the skid entry while the output waits; throughput is one poll per clock while
// poll ready is high. A two-entry report buffer (output register plus skid) keeps polls
// flowing while a report waits; poll ready drops only when both entries are full.
// Synchronous reset (rst high) returns the sequencer to idle, status unknown, limit 3.
// Depends on gmc_pkg and the channel interfaces in gmc_if.
module gate_motion_controller (
  input  logic clk,
  input  logic rst,
  gmc_poll_if.sink     poll,
  gmc_report_if.source report,
  gmc_cfg_if.sink      cfg
);

  // Controller state
  gmc_pkg::phase_t phase;
  logic [2:0]      gate_code;
  logic            error_bit;
  logic            start_request;
  logic            timeout_bit;
  logic [7:0]      tick_count;
  logic            motion_timer_on;
  logic            hold_timer_on;
  logic            button_enabled;
  logic            last_button;
  logic            open_drive;
  logic            close_drive;
  logic [7:0]      timeout_limit;

  // Next values
  gmc_pkg::phase_t phase_next;
  logic [2:0]      gate_code_next;
  logic            error_bit_next;
  logic            start_request_next;
  logic            timeout_bit_next;
  logic [7:0]      tick_count_next;
  logic            motion_timer_on_next;
  logic            hold_timer_on_next;
  logic            button_enabled_next;
  logic            open_drive_next;
  logic            close_drive_next;

  // Values after ticks and button handling, before the sequencer
  logic       mt_pre;
  logic [7:0] tc_pre;
  logic [7:0] tc_inc;
  logic       to_pre;
  logic       err_pre;
  logic       sr_pre;
  logic [1:0] led;

  // Report buffer
  logic             out_valid;
  gmc_pkg::report_t out_data;
  logic             skid_valid;
  gmc_pkg::report_t skid_data;
  gmc_pkg::report_t res;

  logic accept;
  logic drain;

  assign poll.ready = !skid_valid;
  assign accept     = poll.valid && poll.ready;
  assign drain      = report.ready || !out_valid;
  assign cfg.ready  = 1'b1;
  assign tc_inc     = tick_count + 8'd1;

  // Apply timer ticks, remote start and the start button
  always_comb begin
    mt_pre              = motion_timer_on;
    tc_pre              = tick_count;
    to_pre              = timeout_bit;
    err_pre             = error_bit;
    sr_pre              = start_request;
    hold_timer_on_next  = hold_timer_on;
    button_enabled_next = button_enabled;
    if (poll.data.timeout_tick && motion_timer_on) begin
      mt_pre = 1'b0;
      tc_pre = tc_inc;
      if (tc_inc >= timeout_limit) begin
        tc_pre  = 8'd0;
        to_pre  = 1'b1;
        err_pre = 1'b1;
      end
    end
    if (poll.data.remote_start) begin
      sr_pre = 1'b1;
    end
    if (poll.data.hold_tick && hold_timer_on) begin
      hold_timer_on_next  = 1'b0;
      button_enabled_next = 1'b1;
    end
    if ((poll.data.push_button != last_button) && button_enabled_next) begin
      sr_pre = poll.data.push_button;
      if (poll.data.push_button) begin
        hold_timer_on_next  = 1'b1;
        button_enabled_next = 1'b0;
      end
    end
  end

  // Status LED from values before the sequencer
  always_comb begin
    if (err_pre) begin
      led = gmc_pkg::LED_ERROR;
    end else if (gate_code == gmc_pkg::GATE_OPENING || gate_code == gmc_pkg::GATE_CLOSING) begin
      led = gmc_pkg::LED_MOVING;
    end else begin
      led = gmc_pkg::LED_OK;
    end
  end

  // Sequencer next phase
  always_comb begin
    case (phase)
      gmc_pkg::PH_IDLE: begin
        phase_next = sr_pre ? gmc_pkg::PH_DECIDE : gmc_pkg::PH_IDLE;
      end
      gmc_pkg::PH_DECIDE: begin
        phase_next = (gate_code == gmc_pkg::GATE_SHUT ||
                      gate_code == gmc_pkg::GATE_CLOSE_STOP) ?
                     gmc_pkg::PH_OPENING : gmc_pkg::PH_CLOSING;
      end
      gmc_pkg::PH_OPENING: begin
        phase_next = (!poll.data.open_limit || sr_pre || to_pre) ?
                     gmc_pkg::PH_STOP : gmc_pkg::PH_OPENING;
      end
      gmc_pkg::PH_CLOSING: begin
        phase_next = (poll.data.closed_limit || sr_pre || to_pre || !poll.data.photocell) ?
                     gmc_pkg::PH_STOP : gmc_pkg::PH_CLOSING;
      end
      gmc_pkg::PH_STOP: begin
        phase_next = gmc_pkg::PH_IDLE;
      end
      default: begin
        phase_next = gmc_pkg::PH_IDLE;
      end
    endcase
  end

  // Sequencer outputs: relays, gate status, error, timer
  always_comb begin
    gate_code_next       = gate_code;
    error_bit_next       = err_pre;
    start_request_next   = sr_pre;
    timeout_bit_next     = to_pre;
    tick_count_next      = tc_pre;
    motion_timer_on_next = mt_pre;
    open_drive_next      = open_drive;
    close_drive_next     = close_drive;
    case (phase)
      gmc_pkg::PH_IDLE: begin
        if (!poll.data.open_limit && !poll.data.closed_limit) begin
          gate_code_next = gmc_pkg::GATE_OPEN;
        end else if (poll.data.open_limit && poll.data.closed_limit) begin
          gate_code_next = gmc_pkg::GATE_SHUT;
        end
        // Open and closed at once is a bad limit combination
        if (!poll.data.open_limit && poll.data.closed_limit) begin
          error_bit_next = 1'b1;
        end
        if (sr_pre) begin
          start_request_next = 1'b0;
        end
      end
      gmc_pkg::PH_DECIDE: begin
      end
      gmc_pkg::PH_OPENING: begin
        open_drive_next      = 1'b1;
        close_drive_next     = 1'b0;
        motion_timer_on_next = 1'b1;
        gate_code_next       = gmc_pkg::GATE_OPENING;
        if (!poll.data.open_limit) begin
          error_bit_next = 1'b0;
        end else if (sr_pre || to_pre) begin
          start_request_next = 1'b0;
          timeout_bit_next   = 1'b0;
          gate_code_next     = gmc_pkg::GATE_OPEN_STOP;
        end
      end
      gmc_pkg::PH_CLOSING: begin
        open_drive_next      = 1'b0;
        close_drive_next     = 1'b1;
        motion_timer_on_next = 1'b1;
        gate_code_next       = gmc_pkg::GATE_CLOSING;
        if (poll.data.closed_limit) begin
          error_bit_next = 1'b0;
        end else if (sr_pre || to_pre || !poll.data.photocell) begin
          start_request_next = 1'b0;
          timeout_bit_next   = 1'b0;
          gate_code_next     = gmc_pkg::GATE_CLOSE_STOP;
        end
      end
      gmc_pkg::PH_STOP: begin
        open_drive_next      = 1'b0;
        close_drive_next     = 1'b0;
        motion_timer_on_next = 1'b0;
        tick_count_next      = 8'd0;
      end
      default: begin
      end
    endcase
  end

  // Assemble the report
  always_comb begin
    res.open_out         = open_drive_next;
    res.close_out        = close_drive_next;
    res.gate_status      = gate_code_next;
    res.error_flag       = error_bit_next;
    res.status_led       = led;
    res.controller_phase = phase_next;
    res.status_byte      = {error_bit_next, gate_code_next};
  end

  // Advance the controller state on each accepted poll
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= gmc_pkg::PH_IDLE;
      gate_code       <= gmc_pkg::GATE_UNKNOWN;
      error_bit       <= 1'b0;
      start_request   <= 1'b0;
      timeout_bit     <= 1'b0;
      tick_count      <= 8'd0;
      motion_timer_on <= 1'b0;
      hold_timer_on   <= 1'b0;
      button_enabled  <= 1'b1;
      last_button     <= 1'b0;
      open_drive      <= 1'b0;
      close_drive     <= 1'b0;
    end else if (accept) begin
      phase           <= phase_next;
      gate_code       <= gate_code_next;
      error_bit       <= error_bit_next;
      start_request   <= start_request_next;
      timeout_bit     <= timeout_bit_next;
      tick_count      <= tick_count_next;
      motion_timer_on <= motion_timer_on_next;
      hold_timer_on   <= hold_timer_on_next;
      button_enabled  <= button_enabled_next;
      last_button     <= poll.data.push_button;
      open_drive      <= open_drive_next;
      close_drive     <= close_drive_next;
    end
  end

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= gmc_pkg::TIMEOUT_LIMIT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      timeout_limit <= cfg.data;
    end
  end

  // Report buffer control: output register backed by one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (drain) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  // Report buffer payload
  always_ff @(posedge clk) begin
    if (drain) begin
      out_data <= skid_valid ? skid_data : res;
    end else if (accept) begin
      skid_data <= res;
    end
  end

  assign report.valid = out_valid;
  assign report.data  = out_data;

  // Never drive both relays at once
  a_relays_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(open_drive && close_drive))
    else $error("both relays driven");

  // Skid entry only holds a report behind a waiting one
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid valid without output valid");

  // Button is locked exactly while the hold-off timer runs
  a_button_lock: assert property (@(posedge clk) disable iff (rst)
    hold_timer_on != button_enabled)
    else $error("button lock and hold timer disagree");

  // Stopping returns to idle with timer and count cleared
  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == gmc_pkg::PH_STOP) |=>
      (phase == gmc_pkg::PH_IDLE && !motion_timer_on && tick_count == 8'd0 &&
       !open_drive && !close_drive))
    else $error("stop phase did not clear motion state");

  // Relays only change on an accepted poll
  a_relays_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> ($stable(open_drive) && $stable(close_drive)))
    else $error("relay drive changed without a poll");

endmodule

FILE: test/gate_motion_controller_tb.sv
// Testbench for gate_motion_controller: directed polls, then random polls, checked per report.
// Depends on gmc_pkg, the channel interfaces in gmc_if and the gate_motion_controller RTL.
module gate_motion_controller_tb;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int DRAIN_CYCLES    = 4;
  localparam int MAX_SHOWN       = 10;
  localparam int RANDOM_PHASES   = 6;
  localparam int POLLS_PER_PHASE = 200;
  localparam int GATE_TRAVEL     = 6;

  // One directed row: a poll or a limit write, with an optional typed-in report
  typedef struct packed {
    bit               is_limit;
    logic [7:0]       limit_value;
    gmc_pkg::poll_t   poll;
    bit               typed;
    gmc_pkg::report_t want;
  } stim_row_t;

  // Per-poll note: typed-in report that overrides the predicted one
  typedef struct packed {
    bit               typed;
    gmc_pkg::report_t want;
  } poll_note_t;

  logic clk;
  logic rst;

  gmc_poll_if   poll_ch ();
  gmc_report_if report_ch ();
  gmc_cfg_if    cfg_ch ();

  gate_motion_controller dut (
    .clk    (clk),
    .rst    (rst),
    .poll   (poll_ch),
    .report (report_ch),
    .cfg    (cfg_ch)
  );

  // Predicted controller state
  gmc_pkg::phase_t gm_phase;
  logic [2:0]      gm_gate;
  logic            gm_error;
  logic            gm_start_req;
  logic            gm_timeout;
  logic [7:0]      gm_ticks;
  logic            gm_motion_run;
  logic            gm_hold_run;
  logic            gm_button_armed;
  logic            gm_button_prev;
  logic            gm_open_drv;
  logic            gm_close_drv;
  logic [7:0]      gm_limit;

  gmc_pkg::report_t expected_reports[$];
  poll_note_t       poll_notes[$];
  stim_row_t        stim_rows[$];

  int failures = 0;
  int polls_accepted = 0;
  int reports_checked = 0;
  int limit_writes = 0;
  int timeouts_raised = 0;
  int stopped_motions = 0;

  bit hold_off_req = 1'b0;
  bit no_idle = 1'b0;

  // Random plant seen by the poll generator
  logic drv_button = 1'b0;
  int   drv_pos = GATE_TRAVEL;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void reset_gate_model();
    gm_phase        = gmc_pkg::PH_IDLE;
    gm_gate         = gmc_pkg::GATE_UNKNOWN;
    gm_error        = 1'b0;
    gm_start_req    = 1'b0;
    gm_timeout      = 1'b0;
    gm_ticks        = 8'd0;
    gm_motion_run   = 1'b0;
    gm_hold_run     = 1'b0;
    gm_button_armed = 1'b1;
    gm_button_prev  = 1'b0;
    gm_open_drv     = 1'b0;
    gm_close_drv    = 1'b0;
    gm_limit        = gmc_pkg::TIMEOUT_LIMIT_RESET;
  endfunction

  // Advance the predicted controller by one poll and return its report
  function automatic gmc_pkg::report_t advance_gate(gmc_pkg::poll_t p);
    gmc_pkg::report_t r;
    logic [1:0]       led;
    // apply ticks and remote start
    if (p.timeout_tick && gm_motion_run) begin
      gm_motion_run = 1'b0;
      gm_ticks = gm_ticks + 8'd1;
      if (gm_ticks >= gm_limit) begin
        gm_ticks = 8'd0;
        gm_timeout = 1'b1;
        gm_error = 1'b1;
        timeouts_raised++;
      end
    end
    if (p.remote_start) gm_start_req = 1'b1;
    if (p.hold_tick && gm_hold_run) begin
      gm_hold_run = 1'b0;
      gm_button_armed = 1'b1;
    end
    // button edge, locked after a press until the hold tick
    if (p.push_button != gm_button_prev && gm_button_armed) begin
      gm_start_req = p.push_button;
      if (p.push_button) begin
        gm_hold_run = 1'b1;
        gm_button_armed = 1'b0;
      end
    end
    gm_button_prev = p.push_button;
    // LED from pre-sequencer status
    if (gm_error) led = gmc_pkg::LED_ERROR;
    else if (gm_gate == gmc_pkg::GATE_OPENING || gm_gate == gmc_pkg::GATE_CLOSING)
      led = gmc_pkg::LED_MOVING;
    else led = gmc_pkg::LED_OK;
    // sequencer
    case (gm_phase)
      gmc_pkg::PH_IDLE: begin
        if (!p.open_limit && !p.closed_limit) gm_gate = gmc_pkg::GATE_OPEN;
        else if (p.open_limit && p.closed_limit) gm_gate = gmc_pkg::GATE_SHUT;
        if (!p.open_limit && p.closed_limit) gm_error = 1'b1;
        if (gm_start_req) begin
          gm_start_req = 1'b0;
          gm_phase = gmc_pkg::PH_DECIDE;
        end
      end
      gmc_pkg::PH_DECIDE: begin
        gm_phase = (gm_gate == gmc_pkg::GATE_SHUT || gm_gate == gmc_pkg::GATE_CLOSE_STOP) ?
                   gmc_pkg::PH_OPENING : gmc_pkg::PH_CLOSING;
      end
      gmc_pkg::PH_OPENING: begin
        gm_open_drv = 1'b1;
        gm_close_drv = 1'b0;
        gm_motion_run = 1'b1;
        gm_gate = gmc_pkg::GATE_OPENING;
        if (!p.open_limit) begin
          gm_error = 1'b0;
          gm_phase = gmc_pkg::PH_STOP;
        end else if (gm_start_req || gm_timeout) begin
          gm_start_req = 1'b0;
          gm_timeout = 1'b0;
          gm_gate = gmc_pkg::GATE_OPEN_STOP;
          gm_phase = gmc_pkg::PH_STOP;
          stopped_motions++;
        end
      end
      gmc_pkg::PH_CLOSING: begin
        gm_open_drv = 1'b0;
        gm_close_drv = 1'b1;
        gm_motion_run = 1'b1;
        gm_gate = gmc_pkg::GATE_CLOSING;
        if (p.closed_limit) begin
          gm_error = 1'b0;
          gm_phase = gmc_pkg::PH_STOP;
        end else if (gm_start_req || gm_timeout || !p.photocell) begin
          gm_start_req = 1'b0;
          gm_timeout = 1'b0;
          gm_gate = gmc_pkg::GATE_CLOSE_STOP;
          gm_phase = gmc_pkg::PH_STOP;
          stopped_motions++;
        end
      end
      gmc_pkg::PH_STOP: begin
        gm_open_drv = 1'b0;
        gm_close_drv = 1'b0;
        gm_motion_run = 1'b0;
        gm_ticks = 8'd0;
        gm_phase = gmc_pkg::PH_IDLE;
      end
      default: gm_phase = gmc_pkg::PH_IDLE;
    endcase
    r.open_out         = gm_open_drv;
    r.close_out        = gm_close_drv;
    r.gate_status      = gm_gate;
    r.error_flag       = gm_error;
    r.status_led       = led;
    r.controller_phase = gm_phase;
    r.status_byte      = {gm_error, gm_gate};
    return r;
  endfunction

  task automatic flag_failure(string what);
    failures++;
    if (failures <= MAX_SHOWN) $display("mismatch: %s", what);
  endtask

  // Track requests on all three channels, check each report against the oldest expectation
  always @(posedge clk) begin : check_reports
    poll_note_t       note;
    gmc_pkg::report_t predicted;
    gmc_pkg::report_t want;
    gmc_pkg::report_t got;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        gm_limit = cfg_ch.data;
        limit_writes++;
      end
      if (poll_ch.valid && poll_ch.ready) begin
        predicted = advance_gate(poll_ch.data);
        note = '0;
        if (poll_notes.size() != 0) note = poll_notes.pop_front();
        expected_reports.push_back(note.typed ? note.want : predicted);
        polls_accepted++;
      end
      if (report_ch.valid && report_ch.ready) begin
        got = report_ch.data;
        if (expected_reports.size() == 0) begin
          flag_failure($sformatf("report %h with nothing expected", got));
        end else begin
          want = expected_reports.pop_front();
          reports_checked++;
          if (got !== want)
            flag_failure($sformatf({"open %b/%b close %b/%b gate %0d/%0d err %b/%b ",
                                    "led %0d/%0d phase %0d/%0d byte %h/%h (want/got)"},
                                   want.open_out, got.open_out,
                                   want.close_out, got.close_out,
                                   want.gate_status, got.gate_status,
                                   want.error_flag, got.error_flag,
                                   want.status_led, got.status_led,
                                   want.controller_phase, got.controller_phase,
                                   want.status_byte, got.status_byte));
        end
      end
    end
  end

  // End the run when no request moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if (rst || (poll_ch.valid && poll_ch.ready) || (report_ch.valid && report_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no request moved for %0d cycles", WATCHDOG_CYCLES);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Idle length: mostly none, some short, a few long
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Drive report ready: random stalls, one long hold-off on request
  initial begin : report_sink
    int stall_left;
    stall_left = 0;
    report_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        report_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        report_ch.ready <= 1'b1;
      end else if (no_idle) begin
        report_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        report_ch.ready <= 1'b0;
      end else begin
        report_ch.ready <= 1'b1;
        if ($urandom_range(0, 99) < 15) stall_left = idle_length() + 1;
      end
    end
  end

  // Mostly plausible polls from a drifting gate, some pure noise
  function automatic gmc_pkg::poll_t next_random_poll();
    gmc_pkg::poll_t p;
    int             step;
    if ($urandom_range(0, 99) < 15) begin
      p = gmc_pkg::poll_t'(7'($urandom_range(0, 127)));
    end else begin
      if ($urandom_range(0, 9) == 0) drv_button = ~drv_button;
      step = $urandom_range(0, 2);
      if (step == 0 && drv_pos > 0) drv_pos--;
      else if (step == 2 && drv_pos < GATE_TRAVEL) drv_pos++;
      p.push_button  = drv_button;
      p.open_limit   = (drv_pos != 0);
      p.closed_limit = (drv_pos == GATE_TRAVEL);
      if ($urandom_range(0, 49) == 0) begin
        p.open_limit   = 1'b0;
        p.closed_limit = 1'b1;
      end
      p.photocell    = ($urandom_range(0, 19) != 0);
      p.remote_start = ($urandom_range(0, 24) == 0);
      p.timeout_tick = ($urandom_range(0, 3) == 0);
      p.hold_tick    = ($urandom_range(0, 5) == 0);
    end
    return p;
  endfunction

  // Wait until every expected report has come
  task automatic wait_drained();
    @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  // Offer one poll request after an optional gap; return at its acceptance edge
  task automatic send_poll(gmc_pkg::poll_t p, bit typed, gmc_pkg::report_t want, int gap);
    poll_note_t note;
    if (gap > 0) begin
      poll_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    note.typed = typed;
    note.want = want;
    poll_notes.push_back(note);
    poll_ch.valid <= 1'b1;
    poll_ch.data  <= p;
    @(posedge clk);
    while (!poll_ch.ready) @(posedge clk);
  endtask

  // Write the timeout limit once the controller has drained
  task automatic write_limit(logic [7:0] value);
    poll_ch.valid <= 1'b0;
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic add_poll(logic [6:0] bits);
    stim_row_t row;
    row = '0;
    row.poll = gmc_pkg::poll_t'(bits);
    stim_rows.push_back(row);
  endtask

  task automatic add_typed(logic [6:0] bits, gmc_pkg::report_t want);
    stim_row_t row;
    row = '0;
    row.poll = gmc_pkg::poll_t'(bits);
    row.typed = 1'b1;
    row.want = want;
    stim_rows.push_back(row);
  endtask

  task automatic add_limit(logic [7:0] value);
    stim_row_t row;
    row = '0;
    row.is_limit = 1'b1;
    row.limit_value = value;
    stim_rows.push_back(row);
  endtask

  initial begin : stimulus
    int             burst_left;
    int             gap;
    logic [7:0]     phase_limit;
    gmc_pkg::poll_t p;
    burst_left = 0;
    poll_ch.valid <= 1'b0;
    poll_ch.data  <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.data   <= '0;
    rst <= 1'b1;
    reset_gate_model();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Bit order: push_button open_limit closed_limit photocell remote_start
    //            timeout_tick hold_tick
    add_typed(7'b0000000, {1'b0, 1'b0, gmc_pkg::GATE_OPEN, 1'b0, gmc_pkg::LED_OK,
                           gmc_pkg::PH_IDLE, 1'b0, gmc_pkg::GATE_OPEN});
    // bad limit combination raises the error
    add_typed(7'b0010000, {1'b0, 1'b0, gmc_pkg::GATE_OPEN, 1'b1, gmc_pkg::LED_OK,
                           gmc_pkg::PH_IDLE, 1'b1, gmc_pkg::GATE_OPEN});
    // closed; ticks ignored while both timers are stopped
    add_typed(7'b0111011, {1'b0, 1'b0, gmc_pkg::GATE_SHUT, 1'b1, gmc_pkg::LED_ERROR,
                           gmc_pkg::PH_IDLE, 1'b1, gmc_pkg::GATE_SHUT});
    add_poll(7'b1111000);  // press: decide
    add_poll(7'b1111000);  // closed: open
    add_poll(7'b1101000);  // opening
    add_poll(7'b0101010);  // counted tick, release ignored while locked
    add_poll(7'b0101001);  // hold tick unlocks the button
    add_poll(7'b0101010);
    add_poll(7'b0101010);  // third tick: timeout stops the opening
    add_poll(7'b0101000);
    add_limit(8'd0);       // limit of zero
    add_poll(7'b1101000);  // press: decide
    add_poll(7'b1101000);  // stopped open: close
    add_poll(7'b1101000);  // closing
    add_poll(7'b1101010);  // first tick times out at once
    add_poll(7'b1101000);
    add_poll(7'b1101001);  // unlock with the button still held
    add_poll(7'b0101100);  // release clears the remote start request
    add_poll(7'b1101000);  // press: decide
    add_poll(7'b1101000);  // stopped closing: open
    add_poll(7'b1101000);  // opening
    add_poll(7'b1001010);  // open reached as the timeout fires: timeout stays pending
    add_poll(7'b1001000);
    add_poll(7'b0001100);  // remote start: decide
    add_poll(7'b0101000);  // open: close
    add_poll(7'b0101000);  // pending timeout stops the closing at once
    add_poll(7'b0101000);

    // Walk the directed table
    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_limit)
        write_limit(stim_rows[i].limit_value);
      else
        send_poll(stim_rows[i].poll, stim_rows[i].typed, stim_rows[i].want, idle_length());
    end

    // Random phases, each under its own timeout limit
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: phase_limit = 8'd1;
        1: phase_limit = 8'd255;
        2: phase_limit = 8'd2;
        3: phase_limit = 8'($urandom_range(1, 254));
        4: phase_limit = gmc_pkg::TIMEOUT_LIMIT_RESET;
        default: phase_limit = 8'd1;
      endcase
      write_limit(phase_limit);
      no_idle = (ph == 2);
      for (int i = 0; i < POLLS_PER_PHASE; i++) begin
        // hold off the receiver while polls keep coming back to back
        if (ph == 1 && i == 60) begin
          hold_off_req = 1'b1;
          burst_left = 40;
        end
        // pause until every report is in
        if (ph == 3 && i == 100) begin
          poll_ch.valid <= 1'b0;
          wait_drained();
        end
        p = next_random_poll();
        if (no_idle || burst_left > 0) gap = 0;
        else gap = idle_length();
        if (burst_left > 0) burst_left--;
        send_poll(p, 1'b0, '0, gap);
      end
    end
    no_idle = 1'b0;

    // Drain and finish
    poll_ch.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_reports.size() != 0)
      flag_failure($sformatf("%0d reports never came", expected_reports.size()));
    $display("run: %0d polls, %0d reports checked, %0d limit writes (0, 1, 2, 3, 255, random)",
             polls_accepted, reports_checked, limit_writes);
    $display("run: %0d timeouts raised, %0d motions stopped, %0d failures",
             timeouts_raised, stopped_motions, failures);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
